>>> rtl/brrs_pkg.sv
// Shared constants and types for the bitmap round-robin scheduler.
// Depends on nothing; the top level takes these by scoped names.
package brrs_pkg;

  // Slot table geometry and the fill limit.
  localparam int TABLE_DEPTH = 64;
  localparam int MAX_SLOTS   = 64;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Payload widths.
  localparam int ID_W   = 32;
  localparam int REQ_W  = 3;
  localparam int CTR_W  = 64;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD      = 3'd0,
    REQ_REMOVE   = 3'd1,
    REQ_SCHEDULE = 3'd2,
    REQ_YIELD    = 3'd3,
    REQ_TICK     = 3'd4
  } req_t;

  // Result status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

endpackage

>>> rtl/bitmap_round_robin_scheduler_top.sv
// Top level of the bitmap round-robin scheduler: sequencer, slot memory and counters.
// Depends on brrs_pkg for table geometry, widths and request codes.

// One item is accepted when start is high and busy is low; busy then stays high
// while the item is worked on, and its result shows for one cycle with done high,
// which the receiver cannot hold off. A tick, an unknown request, or a request
// rejected up front gives its result in the cycle after acceptance. Add walks the
// slot table one entry per cycle for the duplicate check; remove walks to the
// matching entry and then moves every higher entry down one per cycle. Schedule
// and yield scan the runnable mask one bit per cycle, wrapping. The walks are set
// by the single read port of the slot memory and by the one-bit-per-cycle mask
// scan. A new item may be started in the cycle that done is high. There is no
// clearing pass after reset.
module bitmap_round_robin_scheduler_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [brrs_pkg::REQ_W-1:0]          req_type,
  input  logic [brrs_pkg::ID_W-1:0]           task_id,
  output logic                                done,
  output logic                                status,
  output logic [brrs_pkg::ID_W-1:0]           running_id,
  output logic [brrs_pkg::CNT_W-1:0]          occupied_slots,
  output logic [brrs_pkg::CTR_W-1:0]          ticks_seen,
  output logic [brrs_pkg::CTR_W-1:0]          dispatch_total
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_DEL_SCAN,
    ST_DEL_SHIFT,
    ST_DEL_END,
    ST_SEARCH
  } state_t;

  state_t                               state, state_next;
  logic [brrs_pkg::SLOT_W-1:0]          ptr, ptr_next;
  logic [brrs_pkg::SLOT_W-1:0]          steps, steps_next;
  logic                                 is_yield, is_yield_next;
  logic [brrs_pkg::ID_W-1:0]            req_id, req_id_next;
  logic [brrs_pkg::TABLE_DEPTH-1:0]     mask, mask_next;
  logic [brrs_pkg::CNT_W-1:0]           used, used_next;
  logic [brrs_pkg::CNT_W-1:0]           rdy_cnt, rdy_cnt_next;
  logic [brrs_pkg::SLOT_W-1:0]          cur_slot, cur_slot_next;
  logic [brrs_pkg::ID_W-1:0]            cur_id, cur_id_next;
  logic [brrs_pkg::CTR_W-1:0]           tick_cnt, tick_cnt_next;
  logic [brrs_pkg::CTR_W-1:0]           disp_cnt, disp_cnt_next;
  logic                                 status_next;
  logic                                 done_next;

  // Slot memory ports.
  logic [brrs_pkg::ID_W-1:0]            slot_mem [brrs_pkg::TABLE_DEPTH];
  logic [brrs_pkg::ID_W-1:0]            rdata;
  logic                                 mem_we;
  logic [brrs_pkg::SLOT_W-1:0]          mem_waddr;
  logic [brrs_pkg::ID_W-1:0]            mem_wdata;

  logic                                 accept;
  logic                                 at_last;
  logic [brrs_pkg::CNT_W-1:0]           used_dec;

  assign busy           = (state != ST_IDLE);
  assign accept         = start && !busy;
  assign running_id     = cur_id;
  assign occupied_slots = used;
  assign ticks_seen     = tick_cnt;
  assign dispatch_total = disp_cnt;

  // at_last flags the pointer sitting on the last occupied slot.
  assign at_last  = ((brrs_pkg::CNT_W'(ptr) + brrs_pkg::CNT_W'(1)) == used);
  assign used_dec = used - brrs_pkg::CNT_W'(1);

  // Slot memory: the read address is the pointer's next value, so rdata always
  // holds the entry that ptr points at.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rdata <= slot_mem[ptr_next];
  end

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_next    = state;
    ptr_next      = ptr;
    steps_next    = steps;
    is_yield_next = is_yield;
    req_id_next   = req_id;
    mask_next     = mask;
    used_next     = used;
    rdy_cnt_next  = rdy_cnt;
    cur_slot_next = cur_slot;
    cur_id_next   = cur_id;
    tick_cnt_next = tick_cnt;
    disp_cnt_next = disp_cnt;
    status_next   = status;
    done_next     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = used[brrs_pkg::SLOT_W-1:0];
    mem_wdata     = req_id;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          req_id_next = task_id;
          unique case (brrs_pkg::req_t'(req_type))
            brrs_pkg::REQ_ADD: begin
              if (task_id == '0 || used >= brrs_pkg::CNT_W'(brrs_pkg::MAX_SLOTS)) begin
                status_next = brrs_pkg::STATUS_FAIL;
                done_next   = 1'b1;
              end else if (used == '0) begin
                // Empty table: the id goes straight into slot 0.
                mem_we       = 1'b1;
                mem_waddr    = '0;
                mem_wdata    = task_id;
                mask_next[0] = 1'b1;
                rdy_cnt_next = rdy_cnt + brrs_pkg::CNT_W'(1);
                used_next    = used + brrs_pkg::CNT_W'(1);
                status_next  = brrs_pkg::STATUS_OK;
                done_next    = 1'b1;
              end else begin
                ptr_next   = '0;
                state_next = ST_ADD_SCAN;
              end
            end
            brrs_pkg::REQ_REMOVE: begin
              if (used == '0) begin
                status_next = brrs_pkg::STATUS_FAIL;
                done_next   = 1'b1;
              end else begin
                ptr_next   = '0;
                state_next = ST_DEL_SCAN;
              end
            end
            brrs_pkg::REQ_SCHEDULE: begin
              if (rdy_cnt == '0) begin
                cur_id_next = '0;
                status_next = brrs_pkg::STATUS_FAIL;
                done_next   = 1'b1;
              end else begin
                ptr_next      = cur_slot;
                steps_next    = '0;
                is_yield_next = 1'b0;
                state_next    = ST_SEARCH;
              end
            end
            brrs_pkg::REQ_YIELD: begin
              if (cur_id == '0 || rdy_cnt <= brrs_pkg::CNT_W'(1)) begin
                status_next = brrs_pkg::STATUS_FAIL;
                done_next   = 1'b1;
              end else begin
                ptr_next      = cur_slot + brrs_pkg::SLOT_W'(1);
                steps_next    = '0;
                is_yield_next = 1'b1;
                state_next    = ST_SEARCH;
              end
            end
            brrs_pkg::REQ_TICK: begin
              tick_cnt_next = tick_cnt + brrs_pkg::CTR_W'(1);
              status_next   = brrs_pkg::STATUS_OK;
              done_next     = 1'b1;
            end
            default: begin
              status_next = brrs_pkg::STATUS_FAIL;
              done_next   = 1'b1;
            end
          endcase
        end
      end

      // Duplicate check, one stored id per cycle; append after the last one.
      ST_ADD_SCAN: begin
        if (rdata == req_id) begin
          status_next = brrs_pkg::STATUS_OK;
          done_next   = 1'b1;
          state_next  = ST_IDLE;
        end else if (at_last) begin
          mem_we                                  = 1'b1;
          mask_next[used[brrs_pkg::SLOT_W-1:0]]   = 1'b1;
          rdy_cnt_next                            = rdy_cnt + brrs_pkg::CNT_W'(1);
          used_next                               = used + brrs_pkg::CNT_W'(1);
          status_next                             = brrs_pkg::STATUS_OK;
          done_next                               = 1'b1;
          state_next                              = ST_IDLE;
        end else begin
          ptr_next = ptr + brrs_pkg::SLOT_W'(1);
        end
      end

      // Find the entry to drop.
      ST_DEL_SCAN: begin
        if (rdata == req_id) begin
          if (mask[ptr] && rdy_cnt != '0) begin
            rdy_cnt_next = rdy_cnt - brrs_pkg::CNT_W'(1);
          end
          if (at_last) begin
            state_next = ST_DEL_END;
          end else begin
            ptr_next   = ptr + brrs_pkg::SLOT_W'(1);
            state_next = ST_DEL_SHIFT;
          end
        end else if (at_last) begin
          status_next = brrs_pkg::STATUS_FAIL;
          done_next   = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          ptr_next = ptr + brrs_pkg::SLOT_W'(1);
        end
      end

      // Move each higher entry and its runnable bit down one slot.
      ST_DEL_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr - brrs_pkg::SLOT_W'(1);
        mem_wdata = rdata;
        mask_next[ptr - brrs_pkg::SLOT_W'(1)] = mask[ptr];
        if (at_last) begin
          state_next = ST_DEL_END;
        end else begin
          ptr_next = ptr + brrs_pkg::SLOT_W'(1);
        end
      end

      // Drop the top slot and wrap the current slot if it fell off the end.
      ST_DEL_END: begin
        mask_next[used_dec[brrs_pkg::SLOT_W-1:0]] = 1'b0;
        used_next = used_dec;
        if (brrs_pkg::CNT_W'(cur_slot) >= used_dec && used_dec != '0) begin
          cur_slot_next = '0;
        end
        status_next = brrs_pkg::STATUS_OK;
        done_next   = 1'b1;
        state_next  = ST_IDLE;
      end

      // Rotating scan of the runnable mask, one bit per cycle.
      ST_SEARCH: begin
        if (mask[ptr] && brrs_pkg::CNT_W'(ptr) < used) begin
          cur_slot_next = ptr;
          cur_id_next   = rdata;
          disp_cnt_next = disp_cnt + brrs_pkg::CTR_W'(1);
          status_next   = brrs_pkg::STATUS_OK;
          done_next     = 1'b1;
          state_next    = ST_IDLE;
        end else if (mask[ptr] || steps == '1) begin
          if (!is_yield) begin
            cur_id_next = '0;
          end
          status_next = brrs_pkg::STATUS_FAIL;
          done_next   = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          ptr_next   = ptr + brrs_pkg::SLOT_W'(1);
          steps_next = steps + brrs_pkg::SLOT_W'(1);
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ptr      <= '0;
      mask     <= '0;
      used     <= '0;
      rdy_cnt  <= '0;
      cur_slot <= '0;
      cur_id   <= '0;
      tick_cnt <= '0;
      disp_cnt <= '0;
      status   <= brrs_pkg::STATUS_OK;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      ptr      <= ptr_next;
      mask     <= mask_next;
      used     <= used_next;
      rdy_cnt  <= rdy_cnt_next;
      cur_slot <= cur_slot_next;
      cur_id   <= cur_id_next;
      tick_cnt <= tick_cnt_next;
      disp_cnt <= disp_cnt_next;
      status   <= status_next;
      done     <= done_next;
    end
    steps    <= steps_next;
    is_yield <= is_yield_next;
    req_id   <= req_id_next;
  end

`ifndef ASSERT_OFF
  // A result only follows an accepted item or work in progress.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(accept)))
    else $error("result strobe without an item in progress");

  // The strobe comes with the sequencer back at rest.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  // The table never holds more than its limit.
  a_used_max: assert property (@(posedge clk) disable iff (rst)
    used <= brrs_pkg::CNT_W'(brrs_pkg::MAX_SLOTS))
    else $error("slot count above limit");

  // The runnable count never exceeds the slot count.
  a_rdy_le_used: assert property (@(posedge clk) disable iff (rst)
    rdy_cnt <= used)
    else $error("runnable count above slot count");

  // While idle, no runnable bit sits above the occupied slots.
  a_mask_bound: assert property (@(posedge clk) disable iff (rst)
    (!busy) |-> ((mask >> used) == '0))
    else $error("runnable bit beyond occupied slots");
`endif

endmodule
